[sv/salru_pkg.sv]
// Shared types and constants for the set-associative lookup with true-LRU replacement.
// Used by the controller, datapath and top level; depends on nothing.

package salru_pkg;

	// Field widths of the request and response transactions.
	localparam int SET_INDEX_W = 6;
	localparam int TAG_W       = 20;
	localparam int KIND_W      = 2;
	localparam int WAY_W       = 2;

	// Default geometry.
	localparam int SETS_DEF     = 64;
	localparam int WAYS_DEF     = 4;
	localparam int TAG_BITS_DEF = 20;

	// Kind of access reported with every response.
	typedef enum logic [KIND_W-1:0] {
		KIND_HIT      = 2'd0,
		KIND_COLD     = 2'd1,
		KIND_CONFLICT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SET_INDEX_W-1:0] set_index;
		logic [TAG_W-1:0]       tag;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] access_kind;
		logic [WAY_W-1:0]  way;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_sts_t;

endpackage

[sv/salru_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is set where the interface is instantiated; no other dependencies.

interface salru_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[sv/set_assoc_lru_lookup.sv]
// Top level of the set-associative cache lookup with true-LRU replacement.
// Depends on salru_pkg, salru_stream_if, salru_ctrl, salru_dpath and salru_ram.
//
//   Port  Direction  Payload                    Transaction
//   req   sink       set_index[5:0], tag[19:0]  one access
//   rsp   source     access_kind[1:0], way[1:0] one result per access
//
// An access is accepted in IDLE, where the set's tag and recency rows are read; in
// RESOLVE it compares, chooses the way and writes the recency row back, and the tag
// row on a miss. req is not ready again until that read-modify-write is done.
// After reset a clearing pass writes every set's recency row; req is not ready.
// A result waits in the response register; the next access is accepted meanwhile and
// stalls in RESOLVE only while that register is still occupied.

module set_assoc_lru_lookup #(
	parameter int SETS     = salru_pkg::SETS_DEF,
	parameter int WAYS     = salru_pkg::WAYS_DEF,
	parameter int TAG_BITS = salru_pkg::TAG_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	salru_stream_if.sink   req,
	salru_stream_if.source rsp
);

	salru_pkg::dp_cmd_t cmd;
	salru_pkg::dp_sts_t sts;

	// Sequencing of clearing, acceptance and write-back.
	salru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Storage, way search and response register.
	salru_dpath #(
		.SETS    (SETS),
		.WAYS    (WAYS),
		.TAG_BITS(TAG_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_set_index  (req.payload.set_index),
		.req_tag        (req.payload.tag),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_access_kind(rsp.payload.access_kind),
		.rsp_way        (rsp.payload.way)
	);

endmodule

[sv/salru_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/salru_ctrl.sv]
// Controller for the lookup: clearing pass, request acceptance and write-back sequencing.
// Depends on salru_pkg for the command and status structs.

module salru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output salru_pkg::dp_cmd_t cmd,
	input  salru_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR   = 3'b001,
		ST_IDLE    = 3'b010,
		ST_RESOLVE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.accept     = 1'b0;
		cmd.commit     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// A resolved lookup waits while the response register is still occupied.
	a_hold_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESOLVE && !sts.out_free) |=> (state_q == ST_RESOLVE))
		else $error("lookup left resolve while the response register was busy");

	// The clearing pass ends exactly after its last row.
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sts.clear_last) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not finish after its last row");
`endif

endmodule

[sv/salru_dpath.sv]
// Datapath for the lookup: tag and recency RAMs, way search, LRU update and response register.
// Depends on salru_pkg and salru_ram.

module salru_dpath #(
	parameter int SETS     = salru_pkg::SETS_DEF,
	parameter int WAYS     = salru_pkg::WAYS_DEF,
	parameter int TAG_BITS = salru_pkg::TAG_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  salru_pkg::dp_cmd_t                 cmd,
	output salru_pkg::dp_sts_t                 sts,
	input  logic [salru_pkg::SET_INDEX_W-1:0]  req_set_index,
	input  logic [salru_pkg::TAG_W-1:0]        req_tag,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic [salru_pkg::KIND_W-1:0]       rsp_access_kind,
	output logic [salru_pkg::WAY_W-1:0]        rsp_way
);

	localparam int SAW      = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int META_W   = WAYS + WAYS * WB;
	localparam int TROW_W   = WAYS * TAG_BITS;
	localparam int IDX_SPAN = 2 ** salru_pkg::SET_INDEX_W;

	// Set index folded into range; built as a constant table.
	logic [SAW-1:0] wrap_tbl [IDX_SPAN];
	logic [WAYS*WB-1:0] ident_order;

	for (genvar i = 0; i < IDX_SPAN; i++) begin : g_wrap
		assign wrap_tbl[i] = SAW'(i % SETS);
	end

	for (genvar p = 0; p < WAYS; p++) begin : g_ident
		assign ident_order[p*WB +: WB] = WB'(p);
	end

	logic [SAW-1:0]      set_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SAW-1:0]      clr_q;
	logic [SAW-1:0]      rd_addr;

	assign rd_addr = wrap_tbl[req_set_index];

	// Capture the request on acceptance.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q <= rd_addr;
			tag_q <= TAG_BITS'(req_tag);
		end
	end

	// Clearing pass row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + SAW'(1);
		end
	end

	assign sts.clear_last = (clr_q == SAW'(SETS - 1));

	logic [META_W-1:0] meta_rd;
	logic [META_W-1:0] meta_new;
	logic [META_W-1:0] meta_wdata;
	logic [SAW-1:0]    meta_waddr;
	logic              meta_we;
	logic [TROW_W-1:0] trow_rd;
	logic [TROW_W-1:0] trow_new;
	logic              trow_we;

	// Per-set row: recency order above valid bits.
	salru_ram #(
		.WIDTH(META_W),
		.DEPTH(SETS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.re   (cmd.accept),
		.raddr(rd_addr),
		.rdata(meta_rd)
	);

	// Per-set row of stored tags; contents undefined until a line is filled.
	salru_ram #(
		.WIDTH(TROW_W),
		.DEPTH(SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (trow_we),
		.waddr(set_q),
		.wdata(trow_new),
		.re   (cmd.accept),
		.raddr(rd_addr),
		.rdata(trow_rd)
	);

	logic [WB-1:0]       ord [WAYS];
	logic [WB-1:0]       ord_new [WAYS];
	logic [TAG_BITS-1:0] tg [WAYS];
	logic [WAYS-1:0]     vld;
	logic [WAYS-1:0]     vld_new;
	logic [WAYS-1:0]     hit_p;
	logic [WAYS-1:0]     stop_p;
	logic [WB-1:0]       chosen;
	logic [WB-1:0]       way_sel;
	salru_pkg::kind_t    kind_c;

	assign vld = meta_rd[WAYS-1:0];

	// Unpack the row and test each recency position.
	always_comb begin
		for (int p = 0; p < WAYS; p++) begin
			ord[p]    = meta_rd[WAYS + p*WB +: WB];
			tg[p]     = trow_rd[p*TAG_BITS +: TAG_BITS];
		end
		for (int p = 0; p < WAYS; p++) begin
			hit_p[p]  = vld[ord[p]] && (tg[ord[p]] == tag_q);
			stop_p[p] = !vld[ord[p]] || hit_p[p];
		end
	end

	// The first position from the most recent end that hits or is empty wins.
	always_comb begin
		chosen = WB'(WAYS - 1);
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (stop_p[p]) begin
				chosen = WB'(p);
			end
		end
		if (!(|stop_p)) begin
			kind_c = salru_pkg::KIND_CONFLICT;
		end else if (hit_p[chosen]) begin
			kind_c = salru_pkg::KIND_HIT;
		end else begin
			kind_c = salru_pkg::KIND_COLD;
		end
		way_sel = ord[chosen];
	end

	// Move the chosen way to the front and fill its line on a miss.
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			if (i == 0) begin
				ord_new[i] = way_sel;
			end else if (chosen >= WB'(i)) begin
				ord_new[i] = ord[(i > 0) ? i - 1 : 0];
			end else begin
				ord_new[i] = ord[i];
			end
		end
		vld_new = vld | (WAYS'(1) << way_sel);
		meta_new[WAYS-1:0] = vld_new;
		for (int i = 0; i < WAYS; i++) begin
			meta_new[WAYS + i*WB +: WB] = ord_new[i];
			trow_new[i*TAG_BITS +: TAG_BITS] = (WB'(i) == way_sel) ? tag_q : tg[i];
		end
	end

	// RAM write port: clearing pass or write-back of a resolved lookup.
	always_comb begin
		meta_we = cmd.clear_step || cmd.commit;
		trow_we = cmd.commit && (kind_c != salru_pkg::KIND_HIT);
		if (cmd.clear_step) begin
			meta_waddr = clr_q;
			meta_wdata = {ident_order, {WAYS{1'b0}}};
		end else begin
			meta_waddr = set_q;
			meta_wdata = meta_new;
		end
	end

	logic                         out_valid_q;
	logic [salru_pkg::KIND_W-1:0] out_kind_q;
	logic [salru_pkg::WAY_W-1:0]  out_way_q;

	assign sts.out_free = !out_valid_q || rsp_ready;

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_kind_q <= kind_c;
			out_way_q  <= salru_pkg::WAY_W'(way_sel);
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_access_kind = out_kind_q;
	assign rsp_way         = out_way_q;

`ifndef SYNTHESIS
	// A write-back never overwrites a response that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || rsp_ready))
		else $error("write-back while the response register was occupied");

	// Every write-back presents a response in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("write-back produced no response");
`endif

endmodule

[tb/set_assoc_lru_lookup_tb.sv]
// Self-checking testbench for the set-associative lookup with true-LRU replacement.
// Depends on salru_pkg, salru_stream_if and the set_assoc_lru_lookup RTL, nothing else.

module set_assoc_lru_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SETS         = salru_pkg::SETS_DEF;
	localparam int N_WAYS         = salru_pkg::WAYS_DEF;
	localparam int PHASES         = 4;
	localparam int PHASE_ITEMS    = 460;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int ROWS           = 19;

	// Stall patterns of the response side.
	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_EVERY_FOURTH,
		RX_COIN
	} rx_mode_t;

	// One row of the directed table; known rows carry a result read straight off the rules.
	typedef struct packed {
		logic [salru_pkg::SET_INDEX_W-1:0] set_index;
		logic [salru_pkg::TAG_W-1:0]       tag;
		logic                              known;
		salru_pkg::kind_t                  kind;
		logic [salru_pkg::WAY_W-1:0]       way;
	} access_row_t;

	access_row_t access_rows [ROWS] = '{
		'{6'd0,  20'h00000, 1'b1, salru_pkg::KIND_COLD, 2'd0},
		'{6'd0,  20'h00000, 1'b1, salru_pkg::KIND_HIT,  2'd0},
		'{6'd63, 20'hFFFFF, 1'b1, salru_pkg::KIND_COLD, 2'd0},
		'{6'd63, 20'hFFFFF, 1'b1, salru_pkg::KIND_HIT,  2'd0},
		'{6'd63, 20'h7FFFF, 1'b1, salru_pkg::KIND_COLD, 2'd1},
		'{6'd63, 20'hFFFFE, 1'b1, salru_pkg::KIND_COLD, 2'd2},
		'{6'd63, 20'h00000, 1'b1, salru_pkg::KIND_COLD, 2'd3},
		'{6'd63, 20'hFFFFF, 1'b1, salru_pkg::KIND_HIT,  2'd0},
		'{6'd63, 20'h12345, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd63, 20'h7FFFF, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd63, 20'hFFFFE, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd0,  20'hAAAAA, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd0,  20'h55555, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd0,  20'h0000F, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd0,  20'h00000, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd0,  20'hFFFFF, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd42, 20'h5A5A5, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd21, 20'h5A5A5, 1'b0, salru_pkg::KIND_HIT,  2'd0},
		'{6'd21, 20'h5A5A5, 1'b0, salru_pkg::KIND_HIT,  2'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	salru_stream_if #(.payload_t(salru_pkg::req_t)) req_if ();
	salru_stream_if #(.payload_t(salru_pkg::rsp_t)) rsp_if ();

	set_assoc_lru_lookup i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Shadow copy of the cache directory.
	logic [salru_pkg::TAG_W-1:0] shadow_tag   [N_SETS][N_WAYS];
	bit                          shadow_valid [N_SETS][N_WAYS];
	logic [salru_pkg::WAY_W-1:0] shadow_order [N_SETS][N_WAYS];

	salru_pkg::rsp_t pending_rsp [$];

	// Hand-over from the request driver to the monitor.
	bit              drv_known;
	salru_pkg::rsp_t drv_known_rsp;

	// Random traffic pools, refreshed every phase.
	logic [salru_pkg::TAG_W-1:0]       tag_pool [8];
	logic [salru_pkg::SET_INDEX_W-1:0] hot_sets [4];
	int                                tag_span;

	int fail_cnt;
	int accepted_cnt;
	int checked_cnt;
	int hit_cnt;
	int cold_cnt;
	int conflict_cnt;
	int idle_cycles;
	bit moved;
	salru_pkg::rsp_t lookup_rsp;
	salru_pkg::rsp_t due_rsp;

	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_tick;

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Looks one access up in the shadow directory, updates it and returns the result.
	function automatic salru_pkg::rsp_t cache_lookup(input salru_pkg::req_t access);
		int                          s;
		int                          pos;
		int                          chosen;
		bit                          found;
		salru_pkg::kind_t            kind;
		logic [salru_pkg::WAY_W-1:0] w;
		salru_pkg::rsp_t             res;
		s      = access.set_index % N_SETS;
		kind   = salru_pkg::KIND_CONFLICT;
		chosen = N_WAYS - 1;
		found  = 1'b0;
		// Walk from most recent to least recent.
		for (pos = 0; pos < N_WAYS; pos++) begin
			if (!found) begin
				w = shadow_order[s][pos];
				if (shadow_valid[s][w] && shadow_tag[s][w] == access.tag) begin
					kind   = salru_pkg::KIND_HIT;
					chosen = pos;
					found  = 1'b1;
				end else if (!shadow_valid[s][w]) begin
					kind   = salru_pkg::KIND_COLD;
					chosen = pos;
					found  = 1'b1;
				end
			end
		end
		w = shadow_order[s][chosen];
		if (kind != salru_pkg::KIND_HIT) begin
			shadow_tag[s][w]   = access.tag;
			shadow_valid[s][w] = 1'b1;
		end
		// The chosen way moves to the front of the set's order.
		for (pos = chosen; pos > 0; pos--)
			shadow_order[s][pos] = shadow_order[s][pos - 1];
		shadow_order[s][0] = w;
		res.access_kind = kind;
		res.way         = w;
		return res;
	endfunction

	// Draws one access: mostly a small working set, so that hits and conflicts recur.
	function automatic salru_pkg::req_t random_access();
		salru_pkg::req_t r;
		int              pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r.set_index = hot_sets[$urandom_range(0, 3)];
			r.tag       = tag_pool[$urandom_range(0, tag_span - 1)];
		end else if (pick < 90) begin
			r.set_index = salru_pkg::SET_INDEX_W'($urandom_range(0, N_SETS - 1));
			r.tag       = tag_pool[$urandom_range(0, 7)];
		end else begin
			r.set_index = salru_pkg::SET_INDEX_W'($urandom_range(0, N_SETS - 1));
			r.tag       = salru_pkg::TAG_W'($urandom);
		end
		return r;
	endfunction

	// Presents one transaction from a falling edge and returns at the falling edge after it.
	task automatic put_access(input salru_pkg::req_t r, input bit known,
		input salru_pkg::rsp_t known_rsp);
		drv_known      = known;
		drv_known_rsp  = known_rsp;
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do
			@(posedge clk);
		while (!(req_if.valid && req_if.ready));
		@(negedge clk);
	endtask

	task automatic idle_req(input int n);
		req_if.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Holds requests back until every outstanding result has been returned.
	task automatic drain_rsp();
		req_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_rsp.size() != 0);
	endtask

	// Monitor: predicts accepted requests and checks returned results at the rising edge.
	always @(posedge clk) begin
		moved = 1'b0;
		if (rsp_if.valid && rsp_if.ready) begin
			moved = 1'b1;
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with nothing outstanding: kind %0d way %0d",
					$time, rsp_if.payload.access_kind, rsp_if.payload.way);
				fail_cnt++;
			end else begin
				due_rsp = pending_rsp.pop_front();
				checked_cnt++;
				if (rsp_if.payload.access_kind !== due_rsp.access_kind) begin
					$display("%0t: access_kind expected %0d, got %0d",
						$time, due_rsp.access_kind, rsp_if.payload.access_kind);
					fail_cnt++;
				end
				if (rsp_if.payload.way !== due_rsp.way) begin
					$display("%0t: way expected %0d, got %0d",
						$time, due_rsp.way, rsp_if.payload.way);
					fail_cnt++;
				end
				case (due_rsp.access_kind)
					salru_pkg::KIND_HIT:  hit_cnt++;
					salru_pkg::KIND_COLD: cold_cnt++;
					default:              conflict_cnt++;
				endcase
			end
		end
		if (req_if.valid && req_if.ready) begin
			moved = 1'b1;
			accepted_cnt++;
			lookup_rsp = cache_lookup(req_if.payload);
			if (drv_known)
				lookup_rsp = drv_known_rsp;
			pending_rsp.push_back(lookup_rsp);
		end
		// Watchdog on cycles without any transaction.
		if (arst_n) begin
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no transaction for %0d cycles, %0d results outstanding",
						$time, idle_cycles, pending_rsp.size());
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	// Response side: switches between randomly chosen stall patterns.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS:       rsp_if.ready <= 1'b1;
			RX_MOSTLY:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
			RX_EVERY_FOURTH: rsp_if.ready <= (rx_tick % 4 == 0);
			default:         rsp_if.ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Stimulus: reset, directed table, then phases of random traffic.
	initial begin
		int              i;
		int              ph;
		int              n;
		int              burst_left;
		salru_pkg::req_t r;
		salru_pkg::rsp_t k;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		rx_left        = 0;
		rx_tick        = 0;
		burst_left     = 0;
		for (i = 0; i < N_SETS; i++) begin
			for (n = 0; n < N_WAYS; n++) begin
				shadow_tag[i][n]   = '0;
				shadow_valid[i][n] = 1'b0;
				shadow_order[i][n] = salru_pkg::WAY_W'(n);
			end
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (i = 0; i < ROWS; i++) begin
			r.set_index   = access_rows[i].set_index;
			r.tag         = access_rows[i].tag;
			k.access_kind = access_rows[i].kind;
			k.way         = access_rows[i].way;
			put_access(r, access_rows[i].known, k);
			if (i % 5 == 4)
				idle_req($urandom_range(1, 3));
		end

		// Random phases, each ending with a full drain.
		for (ph = 0; ph < PHASES; ph++) begin
			for (i = 0; i < 8; i++)
				tag_pool[i] = salru_pkg::TAG_W'($urandom);
			for (i = 0; i < 4; i++)
				hot_sets[i] = salru_pkg::SET_INDEX_W'($urandom_range(0, N_SETS - 1));
			tag_span = $urandom_range(3, 7);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				put_access(random_access(), 1'b0, '0);
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					idle_req($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 4) == 0) ?
						$urandom_range(60, 150) : $urandom_range(1, 20);
				end
			end
			drain_rsp();
		end

		// Wind down: let any stray result surface.
		req_if.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d accesses: a %0d-row directed table, then %0d phases of bursty traffic",
			accepted_cnt, ROWS, PHASES);
		$display("Checked %0d results (%0d hits, %0d cold, %0d conflict), %0d mismatches.",
			checked_cnt, hit_cnt, cold_cnt, conflict_cnt, fail_cnt);
		if (fail_cnt == 0 && pending_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[set_assoc_lru_lookup.f]
sv/salru_pkg.sv
sv/salru_stream_if.sv
sv/salru_ram.sv
sv/salru_ctrl.sv
sv/salru_dpath.sv
sv/set_assoc_lru_lookup.sv
tb/set_assoc_lru_lookup_tb.sv
